// ----- src/spn_pkg.sv -----
// Package: sizes, register codes and round functions of the SPN block cipher.
package spn_pkg;

    localparam int BLOCK_BITS = 16;
    localparam int KEY_BITS   = 32;
    localparam int NUM_ROUNDS = (KEY_BITS - BLOCK_BITS) / 4;
    localparam int NUM_FULL   = (NUM_ROUNDS > 1) ? NUM_ROUNDS - 1 : 0;
    localparam int PIPE_STAGES = NUM_FULL + 1;

    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 5;
    localparam int IN_BITS       = 16;
    localparam int OUT_BITS      = 16;

    typedef logic [BLOCK_BITS-1:0]    t_block;
    typedef logic [KEY_BITS-1:0]      t_key;
    typedef logic [CFG_DATA_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        REG_CIPHER_KEY = 2'd0,
        REG_SBOX_TABLE = 2'd1,
        REG_PBOX_TABLE = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    // Key register: low 32 bits of the written word, masked to the key size.
    function automatic t_key key_from_word(input t_word w);
        t_key k;
        for (int i = 0; i < KEY_BITS; i++) begin
            k[i] = (i < 32) ? w[i] : 1'b0;
        end
        return k;
    endfunction

    // Window of BLOCK_BITS key bits starting at bit 4r, taken cyclically.
    function automatic t_block round_key(input t_key key, input int r);
        t_block rk;
        int     start;
        start = ((4 * r) % KEY_BITS + KEY_BITS) % KEY_BITS;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            rk[i] = key[(i + start) % KEY_BITS];
        end
        return rk;
    endfunction

    // Substitute every complete nibble; trailing bits pass unchanged.
    function automatic t_block sub_layer(input t_block s, input t_word sbox);
        t_block     o;
        logic [3:0] nib;
        o = s;
        for (int i = 0; i + 4 <= BLOCK_BITS; i += 4) begin
            nib      = s[i +: 4];
            o[i +: 4] = sbox[{nib, 2'b00} +: 4];
        end
        return o;
    endfunction

    // Output bit n takes source bit (entry n mod 16), folded into the block.
    function automatic t_block perm_layer(input t_block s, input t_word pbox);
        t_block o;
        int     src;
        for (int n = 0; n < BLOCK_BITS; n++) begin
            src = int'(pbox[4 * (n % 16) +: 4]);
            if (src >= BLOCK_BITS) begin
                src = src - BLOCK_BITS;
            end
            o[n] = s[src];
        end
        return o;
    endfunction

endpackage

// ----- src/spn_round.sv -----
// One SPN round: key mix, s-box layer and an optional bit permutation.
module spn_round (
    input  spn_pkg::t_block i_state,
    input  spn_pkg::t_block i_round_key,
    input  spn_pkg::t_word  i_sbox,
    input  spn_pkg::t_word  i_pbox,
    input  logic            i_last,
    output spn_pkg::t_block o_state
);

    spn_pkg::t_block mixed;
    spn_pkg::t_block subst;

    always_comb begin
        mixed = i_state ^ i_round_key;
        subst = spn_pkg::sub_layer(mixed, i_sbox);
        // Drop the permutation on the closing step.
        o_state = i_last ? subst : spn_pkg::perm_layer(subst, i_pbox);
    end

endmodule

// ----- src/spn_block_encrypt.sv -----
// Top level: SPN block encryption with APB configuration registers.
//
// Usage:
//   Input channel: drive i_plain_block and raise start; the block transfer
//   happens at each rising edge where start is high and busy is low. busy
//   stays low, so a new block may be given in every cycle.
//   Output channel: o_done is high for exactly one cycle with o_cipher_block;
//   the receiver must take it in that cycle, it cannot stall the block.
//   Timing: the block passes the input register, then the unrolled rounds
//   into the result register, which raises o_done with the result.
//   Throughput: one block per cycle; busy never rises, and the depth of the
//   unrolled rounds between the two registers sets only the clock period.
//   Configuration: APB with 64-bit data; cipher_key at 0x00, sbox_table at
//   0x08, pbox_table at 0x10. Writes complete in the access cycle (pready is
//   always high); reads return the stored value. Write only while idle.
//   Reset (i_rst_n low, synchronous): clears all three registers and drops
//   any block in flight; no result is strobed for it.
module spn_block_encrypt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [spn_pkg::IN_BITS-1:0]        i_plain_block,
    output logic                               o_done,
    output logic [spn_pkg::OUT_BITS-1:0]       o_cipher_block,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spn_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [spn_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [spn_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    // Configuration registers.
    spn_pkg::t_key   r_key;
    spn_pkg::t_word  r_sbox;
    spn_pkg::t_word  r_pbox;

    // Input register and result register.
    logic            r_in_valid;
    spn_pkg::t_block r_in_block;
    logic            r_done;
    spn_pkg::t_block r_out_block;
    spn_pkg::t_block n_out_block;

    logic               accept;
    logic               cfg_wr;
    spn_pkg::t_reg_idx  cfg_idx;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = spn_pkg::t_reg_idx'(paddr[spn_pkg::CFG_ADDR_BITS-1:3]);

    // Register writes; addresses beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_sbox <= '0;
            r_pbox <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                spn_pkg::REG_CIPHER_KEY: r_key  <= spn_pkg::key_from_word(pwdata);
                spn_pkg::REG_SBOX_TABLE: r_sbox <= pwdata;
                spn_pkg::REG_PBOX_TABLE: r_pbox <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        case (cfg_idx)
            spn_pkg::REG_CIPHER_KEY: prdata = spn_pkg::CFG_DATA_BITS'(r_key);
            spn_pkg::REG_SBOX_TABLE: prdata = r_sbox;
            spn_pkg::REG_PBOX_TABLE: prdata = r_pbox;
            default:                 prdata = '0;
        endcase
    end

    // Capture the transfer; zero-extend or truncate to the block size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_block <= spn_pkg::BLOCK_BITS'({{spn_pkg::BLOCK_BITS{1'b0}}, i_plain_block});
        end
    end

    // Unrolled rounds: full rounds, then the closing key mix and s-box.
    spn_pkg::t_block stage [spn_pkg::PIPE_STAGES+1];

    assign stage[0] = r_in_block;

    for (genvar g = 0; g < spn_pkg::NUM_FULL; g++) begin : g_full
        spn_round u_round (
            .i_state     (stage[g]),
            .i_round_key (spn_pkg::round_key(r_key, g)),
            .i_sbox      (r_sbox),
            .i_pbox      (r_pbox),
            .i_last      (1'b0),
            .o_state     (stage[g+1])
        );
    end

    spn_round u_final (
        .i_state     (stage[spn_pkg::NUM_FULL]),
        .i_round_key (spn_pkg::round_key(r_key, spn_pkg::NUM_ROUNDS)),
        .i_sbox      (r_sbox),
        .i_pbox      (r_pbox),
        .i_last      (1'b1),
        .o_state     (stage[spn_pkg::PIPE_STAGES])
    );

    assign n_out_block = stage[spn_pkg::PIPE_STAGES];

    // Result register: strobe for one cycle, payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_block <= n_out_block;
        end
    end

    assign o_done         = r_done;
    assign o_cipher_block = spn_pkg::OUT_BITS'({{spn_pkg::OUT_BITS{1'b0}}, r_out_block});

`ifndef ASSERT_OFF
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("transfer not followed by a result strobe");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept && i_rst_n, 2))
        else $error("result strobe without a matching input transfer");

    a_sbox_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && cfg_idx == spn_pkg::REG_SBOX_TABLE) |=> (r_sbox == $past(pwdata)))
        else $error("sbox_table write not reflected");
`endif

endmodule
